>>> hdl/rotation_matrix_to_euler_top_assert.svh
// Assertion macros for the rotation matrix to Euler angle block
`ifndef ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RME_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error(msg);

`endif

>>> hdl/rme_pkg.sv
// Shared types, constants and the arctangent table of the Euler angle block
package rme_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 28;
  localparam int unsigned PRESCALE         = 26;
  localparam int unsigned SQRT_STEPS       = 32;
  localparam int unsigned ENTRY_W          = 32;
  localparam int unsigned OP_W             = 33;
  localparam int unsigned VEC_W            = 64;
  localparam int unsigned ANG_W            = 35;
  localparam int unsigned OUT_W            = 31;
  localparam int unsigned THR_W            = 31;

  localparam logic [THR_W-1:0] THRESH_RESET = 31'd1074;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_MAX     = 35'sd843314857;

  // atan(2^-i) in Q2.30 for the first stages; beyond, it is 2^(30-i)
  localparam logic [29:0] ATAN_SMALL [0:10] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576
  };

  // Matrix entries carried alongside the root pipeline
  typedef struct packed {
    logic signed [ENTRY_W-1:0] r00;
    logic signed [ENTRY_W-1:0] r10;
    logic signed [ENTRY_W-1:0] r20;
    logic signed [ENTRY_W-1:0] r21;
    logic signed [ENTRY_W-1:0] r22;
    logic signed [ENTRY_W-1:0] r11;
    logic signed [ENTRY_W-1:0] r12;
  } mat_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
    logic signed [ANG_W-1:0] res;
    res = '0;
    if (i < 11) begin
      res = ANG_W'(ATAN_SMALL[i[3:0]]);
    end else if (i <= 30) begin
      res = ANG_W'(64'd1 << (30 - i));
    end
    return res;
  endfunction

endpackage

>>> hdl/rme_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per stage
module rme_isqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [63:0]                         num_i,
  input  rme_pkg::mat_t                       side_i,
  output logic                                valid_o,
  output logic [rme_pkg::ENTRY_W-1:0]         root_o,
  output rme_pkg::mat_t                       side_o
);

  localparam int unsigned N = rme_pkg::SQRT_STEPS;

  logic [63:0]   num_w   [0:N];
  logic [63:0]   res_w   [0:N];
  rme_pkg::mat_t side_w  [0:N];
  logic          valid_w [0:N];

  logic [63:0]   num_q   [0:N-1];
  logic [63:0]   res_q   [0:N-1];
  rme_pkg::mat_t side_q  [0:N-1];
  logic          valid_q [0:N-1];

  assign num_w[0]   = num_i;
  assign res_w[0]   = '0;
  assign side_w[0]  = side_i;
  assign valid_w[0] = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic [63:0] num_d;
    logic [63:0] res_d;

    // Try the next root bit; keep it when the remainder allows
    always_comb begin
      trial = res_w[k] + BIT;
      if (num_w[k] >= trial) begin
        num_d = num_w[k] - trial;
        res_d = (res_w[k] >> 1) + BIT;
      end else begin
        num_d = num_w[k];
        res_d = res_w[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= num_d;
      res_q[k]  <= res_d;
      side_q[k] <= side_w[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_w[k];
      end
    end

    assign num_w[k+1]   = num_q[k];
    assign res_w[k+1]   = res_q[k];
    assign side_w[k+1]  = side_q[k];
    assign valid_w[k+1] = valid_q[k];
  end

  assign valid_o = valid_w[N];
  assign root_o  = res_w[N][rme_pkg::ENTRY_W-1:0];
  assign side_o  = side_w[N];

endmodule

>>> hdl/rme_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q3.28
module rme_cordic #(
  parameter int unsigned STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic signed [rme_pkg::OP_W-1:0]   y_i,
  input  logic signed [rme_pkg::OP_W-1:0]   x_i,
  output logic signed [rme_pkg::OUT_W-1:0]  angle_o
);

  localparam int unsigned VW = rme_pkg::VEC_W;
  localparam int unsigned AW = rme_pkg::ANG_W;

  logic signed [VW-1:0] px_q   [0:STEPS];
  logic signed [VW-1:0] py_q   [0:STEPS];
  logic signed [AW-1:0] z_q    [0:STEPS];
  logic                 zero_q [0:STEPS];

  logic signed [VW-1:0] px0;
  logic signed [VW-1:0] py0;

  // Prescale, then fold the left half-plane by a quarter turn
  always_comb begin
    px0 = VW'(x_i) <<< rme_pkg::PRESCALE;
    py0 = VW'(y_i) <<< rme_pkg::PRESCALE;
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (px0 < 0) begin
      if (py0 >= 0) begin
        px_q[0] <= py0;
        py_q[0] <= -px0;
        z_q[0]  <= rme_pkg::ANG_HALF_PI;
      end else begin
        px_q[0] <= -py0;
        py_q[0] <= px0;
        z_q[0]  <= -rme_pkg::ANG_HALF_PI;
      end
    end else begin
      px_q[0] <= px0;
      py_q[0] <= py0;
      z_q[0]  <= '0;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [AW-1:0] ATAN_I = rme_pkg::atan_step(i);
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (py_q[i] >= 0) begin
        px_q[i+1] <= px_q[i] + (py_q[i] >>> i);
        py_q[i+1] <= py_q[i] - (px_q[i] >>> i);
        z_q[i+1]  <= z_q[i] + ATAN_I;
      end else begin
        px_q[i+1] <= px_q[i] - (py_q[i] >>> i);
        py_q[i+1] <= py_q[i] + (px_q[i] >>> i);
        z_q[i+1]  <= z_q[i] - ATAN_I;
      end
    end
  end

  // Round Q2.30 to Q3.28 and clamp to +-pi
  logic signed [AW-1:0]               rnd;
  logic signed [rme_pkg::OUT_W-1:0]   angle_d;
  logic signed [rme_pkg::OUT_W-1:0]   angle_q;

  always_comb begin
    rnd = (z_q[STEPS] + AW'(2)) >>> 2;
    if (zero_q[STEPS]) begin
      angle_d = '0;
    end else if (rnd > rme_pkg::ANG_MAX) begin
      angle_d = rme_pkg::OUT_W'(rme_pkg::ANG_MAX);
    end else if (rnd < -rme_pkg::ANG_MAX) begin
      angle_d = rme_pkg::OUT_W'(-rme_pkg::ANG_MAX);
    end else begin
      angle_d = rnd[rme_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

>>> hdl/rotation_matrix_to_euler_top.sv
// Top level: rotation matrix to ZYX Euler angles, fully pipelined
// A matrix may be started in every cycle; busy stays low. Each result reaches
// result_valid_o through three input/multiply/sum stages, a 32-stage square
// root of r00^2 + r10^2, one threshold-and-select stage, three parallel
// CORDICs of CORDIC_STEPS + 2 stages and an output register. The receiver
// cannot hold results off, so a strobe is never repeated. The threshold is
// written through the cfg channel, which is always ready; write it only while
// no request is in flight.
module rotation_matrix_to_euler_top #(
  parameter int unsigned CORDIC_STEPS = rme_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r00_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r10_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r20_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r21_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r22_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r11_i,
  input  logic signed [rme_pkg::ENTRY_W-1:0]  r12_i,
  output logic                                result_valid_o,
  output logic signed [rme_pkg::OUT_W-1:0]    roll_o,
  output logic signed [rme_pkg::OUT_W-1:0]    pitch_o,
  output logic signed [rme_pkg::OUT_W-1:0]    yaw_o,
  output logic                                singular_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rme_pkg::THR_W-1:0]           cfg_data_i
);

  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int unsigned TOTAL_LAT  = 3 + rme_pkg::SQRT_STEPS + 1 + CORDIC_LAT + 1;
  localparam int unsigned EW = rme_pkg::ENTRY_W;
  localparam int unsigned OW = rme_pkg::OP_W;

  // Threshold register
  logic [rme_pkg::THR_W-1:0] thr_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rme_pkg::THRESH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Stage 0: capture the request
  rme_pkg::mat_t s0_mat_q;
  logic          s0_valid_q;

  always_ff @(posedge clk_i) begin
    s0_mat_q <= '{r00: r00_i, r10: r10_i, r20: r20_i, r21: r21_i,
                  r22: r22_i, r11: r11_i, r12: r12_i};
  end

  // Stage 1: squares of the first column's top entries
  rme_pkg::mat_t      s1_mat_q;
  logic signed [63:0] sq00_q;
  logic signed [63:0] sq10_q;
  logic               s1_valid_q;

  always_ff @(posedge clk_i) begin
    s1_mat_q <= s0_mat_q;
    sq00_q   <= s0_mat_q.r00 * s0_mat_q.r00;
    sq10_q   <= s0_mat_q.r10 * s0_mat_q.r10;
  end

  // Stage 2: sum of squares
  rme_pkg::mat_t s2_mat_q;
  logic [63:0]   sum_q;
  logic          s2_valid_q;

  always_ff @(posedge clk_i) begin
    s2_mat_q <= s1_mat_q;
    sum_q    <= $unsigned(sq00_q) + $unsigned(sq10_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start && !busy;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Square root pipeline
  logic          rt_valid;
  logic [EW-1:0] rt_sy;
  rme_pkg::mat_t rt_mat;

  rme_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .num_i   (sum_q),
    .side_i  (s2_mat_q),
    .valid_o (rt_valid),
    .root_o  (rt_sy),
    .side_o  (rt_mat)
  );

  // Threshold compare and operand selection
  logic                 sing;
  logic signed [OW-1:0] pit_y_q, pit_x_q, rol_y_q, rol_x_q, yaw_y_q, yaw_x_q;
  logic                 sel_sing_q;
  logic                 sel_valid_q;

  assign sing = rt_sy < EW'(thr_q);

  always_ff @(posedge clk_i) begin
    sel_sing_q <= sing;
    pit_y_q    <= -OW'(rt_mat.r20);
    pit_x_q    <= $signed({1'b0, rt_sy});
    yaw_y_q    <= OW'(rt_mat.r10);
    yaw_x_q    <= OW'(rt_mat.r00);
    if (sing) begin
      rol_y_q <= -OW'(rt_mat.r12);
      rol_x_q <= OW'(rt_mat.r11);
    end else begin
      rol_y_q <= OW'(rt_mat.r21);
      rol_x_q <= OW'(rt_mat.r22);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else begin
      sel_valid_q <= rt_valid;
    end
  end

  // Three angle units in parallel
  logic signed [rme_pkg::OUT_W-1:0] roll_ang, pitch_ang, yaw_ang;

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i), .y_i (rol_y_q), .x_i (rol_x_q), .angle_o (roll_ang)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i), .y_i (pit_y_q), .x_i (pit_x_q), .angle_o (pitch_ang)
  );

  rme_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i), .y_i (yaw_y_q), .x_i (yaw_x_q), .angle_o (yaw_ang)
  );

  // Valid and singular flag follow the angle units
  logic dly_valid_q [0:CORDIC_LAT-1];
  logic dly_sing_q  [0:CORDIC_LAT-1];

  always_ff @(posedge clk_i) begin
    dly_sing_q[0] <= sel_sing_q;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      dly_sing_q[k] <= dly_sing_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CORDIC_LAT; k++) begin
        dly_valid_q[k] <= 1'b0;
      end
    end else begin
      dly_valid_q[0] <= sel_valid_q;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        dly_valid_q[k] <= dly_valid_q[k-1];
      end
    end
  end

  // Output register; yaw forced to zero in gimbal lock
  logic                             out_valid_q;
  logic                             out_sing_q;
  logic signed [rme_pkg::OUT_W-1:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk_i) begin
    out_sing_q <= dly_sing_q[CORDIC_LAT-1];
    roll_q     <= roll_ang;
    pitch_q    <= pitch_ang;
    yaw_q      <= dly_sing_q[CORDIC_LAT-1] ? '0 : yaw_ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dly_valid_q[CORDIC_LAT-1];
    end
  end

  assign result_valid_o = out_valid_q;
  assign singular_o     = out_sing_q;
  assign roll_o         = roll_q;
  assign pitch_o        = pitch_q;
  assign yaw_o          = yaw_q;

  // Checks
`include "rotation_matrix_to_euler_top_assert.svh"

  `RME_ASSERT_IMPL(a_latency, start && !busy, ##TOTAL_LAT result_valid_o, "result strobe missing")
  `RME_ASSERT_IMPL(a_yaw_sing, result_valid_o && singular_o, yaw_o == '0, "yaw not zero when singular")
  `RME_ASSERT_IMPL(a_roll_clamp, result_valid_o, (roll_o <= 31'sd843314857) && (roll_o >= -31'sd843314857), "roll out of range")
  `RME_ASSERT_NEXT(a_sel_follow, rt_valid, sel_valid_q, "select stage lost a request")

endmodule
